/* rtl/rau_pkg.sv */
// shared types and constants for the rational arithmetic unit
`timescale 1ns / 1ps
package rau_pkg;
  localparam int WordBits = 32;
  localparam int MagBits  = 64;

  typedef enum logic [3:0] {
    FuncAdd = 4'd0, FuncSub = 4'd1, FuncMul = 4'd2, FuncDiv = 4'd3,
    FuncNeg = 4'd4, FuncInc = 4'd5, FuncDec = 4'd6, FuncRed = 4'd7,
    FuncCmp = 4'd8
  } func_e;

  localparam logic [1:0] StatusOk  = 2'd0;
  localparam logic [1:0] StatusZero = 2'd1;
  localparam logic [1:0] StatusOvf = 2'd2;

  typedef enum logic [3:0] {
    StIdle, StLoad, StMul1, StMul2, StMul3, StSum, StGcdChk, StGcdStep,
    StDivN, StDivD, StCheck, StOut
  } state_e;

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic mul3;
    logic sum;
    logic gcd_step;
    logic div_n_start;
    logic div_d_start;
    logic check;
  } cmd_t;

  typedef struct packed {
    logic early_done;
    logic gcd_done;
    logic mod_done;
  } sts_t;
endpackage

/* rtl/rau_divider.sv */
// restoring 64 bit unsigned divider, one quotient bit per cycle
`timescale 1ns / 1ps
module rau_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [rau_pkg::MagBits-1:0] dividend_i,
  input  logic [rau_pkg::MagBits-1:0] divisor_i,
  output logic                        done_o,
  output logic [rau_pkg::MagBits-1:0] quot_o,
  output logic [rau_pkg::MagBits-1:0] rem_o
);
  import rau_pkg::*;
  localparam int CntBits = $clog2(MagBits + 1);

  logic [MagBits-1:0] quot_q, quot_d, rem_q, rem_d, dsr_q, dsr_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic [MagBits:0]   trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q, quot_q[MagBits-1]} - {1'b0, dsr_q};
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
      cnt_d  = CntBits'(MagBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[MagBits]) begin
        rem_d  = trial[MagBits-1:0];
        quot_d = {quot_q[MagBits-2:0], 1'b1};
      end else begin
        rem_d  = {rem_q[MagBits-2:0], quot_q[MagBits-1]};
        quot_d = {quot_q[MagBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
  end

  assign done_o = busy_q && (cnt_q == CntBits'(1)) && !start_i;
  // result visible the cycle after done
  assign quot_o = quot_q;
  assign rem_o  = rem_q;
endmodule

/* rtl/rau_datapath.sv */
// operand registers, multiplier, adder, gcd and reduction datapath
`timescale 1ns / 1ps
module rau_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rau_pkg::cmd_t                cmd_i,
  output rau_pkg::sts_t                sts_o,
  input  logic [3:0]                   func_i,
  input  logic [rau_pkg::WordBits-1:0] a_num_i,
  input  logic [rau_pkg::WordBits-1:0] a_den_i,
  input  logic [rau_pkg::WordBits-1:0] b_num_i,
  input  logic [rau_pkg::WordBits-1:0] b_den_i,
  output logic [rau_pkg::WordBits-1:0] res_num_o,
  output logic [rau_pkg::WordBits-2:0] res_den_o,
  output logic                         less_o,
  output logic                         equal_o,
  output logic                         greater_o,
  output logic [1:0]                   status_o
);
  import rau_pkg::*;
  localparam int W = WordBits;
  localparam int M = MagBits;
  localparam logic [M-1:0] Lim = M'((64'd1 << (W - 1)) - 64'd1);

  logic [3:0]   f_q;
  logic         an_s_q, ad_s_q, bn_s_q, bd_s_q;
  logic [W-1:0] an_m_q, ad_m_q, bn_m_q, bd_m_q;
  logic [M-1:0] p_q, p_d;
  logic         ps_q, ps_d;
  logic [M-1:0] t1_q, nm_q, dm_q;
  logic         t1_s_q, ns_q, ds_q;
  logic [M-1:0] x_q, y_q, g_q, qn_q;
  logic         early_q;
  logic [W-1:0] rn_q;
  logic [W-2:0] rd_q;
  logic         lt_q, eq_q, gt_q;
  logic [1:0]   st_q;

  function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  // signed magnitude add
  function automatic logic [M:0] sm_add(input logic as, input logic [M-1:0] am,
                                         input logic bs, input logic [M-1:0] bm);
    if (as == bs) return {as, am + bm};
    else if (am >= bm) return {as, am - bm};
    else return {bs, bm - am};
  endfunction

  logic         div_start, div_done;
  logic [M-1:0] div_a, div_b, div_qo, div_ro;
  logic [M:0]   sum;
  logic [M:0]   inc_sum, dec_sum;
  logic         unary, zero_err;
  logic [M-1:0] nlim;
  logic         rneg;
  logic [W-1:0] ain_n, ain_d, bin_n, bin_d;
  logic [3:0]   fu;

  assign ain_n = a_num_i;
  assign ain_d = a_den_i;
  assign bin_n = b_num_i;
  assign bin_d = b_den_i;

  // multiplier operand selection
  logic [W-1:0] ma, mb;
  logic         msgn;
  always_comb begin
    ma = an_m_q; mb = bd_m_q; msgn = an_s_q ^ bd_s_q;
    if (cmd_i.mul2) begin
      case (f_q)
        FuncMul: begin ma = an_m_q; mb = bn_m_q; msgn = an_s_q ^ bn_s_q; end
        FuncDiv: begin ma = ad_m_q; mb = bn_m_q; msgn = ad_s_q ^ bn_s_q; end
        default: begin ma = bn_m_q; mb = ad_m_q; msgn = bn_s_q ^ ad_s_q; end
      endcase
    end else if (cmd_i.mul3) begin
      // divide keeps a_den * b_num as its denominator
      if (f_q == FuncDiv) begin
        ma = ad_m_q; mb = bn_m_q; msgn = ad_s_q ^ bn_s_q;
      end else begin
        ma = ad_m_q; mb = bd_m_q; msgn = ad_s_q ^ bd_s_q;
      end
    end
    p_d  = M'(ma) * M'(mb);
    ps_d = msgn;
  end

  always_comb begin
    fu = f_q;
    case (fu)
      FuncSub, FuncCmp: sum = sm_add(t1_s_q, t1_q, !ps_q, p_q);
      default:          sum = sm_add(t1_s_q, t1_q, ps_q, p_q);
    endcase
  end

  assign inc_sum = sm_add(an_s_q, M'(an_m_q), ad_s_q, M'(ad_m_q));
  assign dec_sum = sm_add(an_s_q, M'(an_m_q), !ad_s_q, M'(ad_m_q));

  always_comb begin
    unary = (func_i >= 4'(FuncNeg)) && (func_i <= 4'(FuncRed));
    zero_err = (a_den_i == '0) || (!unary && (b_den_i == '0)) ||
               ((func_i == 4'(FuncDiv)) && (b_num_i == '0));
  end

  assign div_start = cmd_i.div_n_start || cmd_i.div_d_start || cmd_i.gcd_step;
  assign div_a = cmd_i.gcd_step ? x_q : (cmd_i.div_n_start ? nm_q : dm_q);
  assign div_b = cmd_i.gcd_step ? y_q : g_q;

  rau_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_a), .divisor_i(div_b),
    .done_o(div_done), .quot_o(div_qo), .rem_o(div_ro)
  );

  logic div_done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) div_done_q <= 1'b0;
    else div_done_q <= div_done;
  end

  assign rneg = (qn_q != '0) && (ns_q != ds_q);
  assign nlim = rneg ? Lim + 1'b1 : Lim;

  // gcd and reduction state captured from divider
  typedef enum logic [1:0] {DvGcd, DvN, DvD} dv_e;
  dv_e dv_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_q <= DvGcd;
    else if (cmd_i.gcd_step) dv_q <= DvGcd;
    else if (cmd_i.div_n_start) dv_q <= DvN;
    else if (cmd_i.div_d_start) dv_q <= DvD;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      f_q <= func_i;
      an_s_q <= ain_n[W-1]; an_m_q <= mag_of(ain_n);
      ad_s_q <= ain_d[W-1]; ad_m_q <= mag_of(ain_d);
      bn_s_q <= bin_n[W-1]; bn_m_q <= mag_of(bin_n);
      bd_s_q <= bin_d[W-1]; bd_m_q <= mag_of(bin_d);
      early_q <= 1'b0;
      rn_q <= '0; rd_q <= '0; lt_q <= 1'b0; eq_q <= 1'b0; gt_q <= 1'b0;
      st_q <= StatusOk;
      if (func_i > 4'(FuncCmp)) early_q <= 1'b1;
      else if (zero_err) begin early_q <= 1'b1; st_q <= StatusZero; end
    end
    if (cmd_i.mul1 || cmd_i.mul2 || cmd_i.mul3) begin
      p_q <= p_d; ps_q <= ps_d;
    end
    if (cmd_i.mul2) begin t1_q <= p_q; t1_s_q <= ps_q; end
    if (cmd_i.mul3) begin
      // numerator choice
      case (f_q)
        FuncAdd, FuncSub, FuncCmp: begin nm_q <= sum[M-1:0]; ns_q <= sum[M]; end
        FuncDiv: begin nm_q <= t1_q; ns_q <= t1_s_q; end
        default: begin nm_q <= p_q; ns_q <= ps_q; end
      endcase
    end
    if (cmd_i.sum) begin
      g_q <= '0;
      case (f_q)
        FuncAdd, FuncSub, FuncMul, FuncDiv: begin
          dm_q <= p_q; ds_q <= ps_q;
          x_q <= nm_q; y_q <= p_q;
        end
        FuncCmp: begin
          early_q <= 1'b1;
          if (nm_q == '0) eq_q <= 1'b1;
          else if (ns_q != ps_q) lt_q <= 1'b1;
          else gt_q <= 1'b1;
        end
        default: begin
          // unary ops: numerator from a_num (a_num +/- a_den for inc and dec), denominator a_den
          dm_q <= M'(ad_m_q); ds_q <= ad_s_q;
          case (f_q)
            FuncNeg: begin nm_q <= M'(an_m_q); ns_q <= !an_s_q; x_q <= M'(an_m_q); end
            FuncInc: begin
              nm_q <= inc_sum[M-1:0];
              ns_q <= inc_sum[M];
              x_q  <= inc_sum[M-1:0];
            end
            FuncDec: begin
              nm_q <= dec_sum[M-1:0];
              ns_q <= dec_sum[M];
              x_q  <= dec_sum[M-1:0];
            end
            default: begin nm_q <= M'(an_m_q); ns_q <= an_s_q; x_q <= M'(an_m_q); end
          endcase
          y_q <= M'(ad_m_q);
        end
      endcase
    end
    if (div_done_q) begin
      case (dv_q)
        DvGcd: begin x_q <= y_q; y_q <= div_ro; g_q <= y_q; end
        DvN:   qn_q <= div_qo;
        default: dm_q <= div_qo;
      endcase
    end
    if (cmd_i.check) begin
      if (dm_q > Lim || qn_q > nlim) st_q <= StatusOvf;
      else begin
        rn_q <= rneg ? W'(~qn_q + 1'b1) : W'(qn_q);
        rd_q <= dm_q[W-2:0];
      end
    end
  end

  assign sts_o.early_done = early_q;
  assign sts_o.gcd_done   = (y_q == '0);
  assign sts_o.mod_done   = div_done_q;

  assign res_num_o = rn_q;
  assign res_den_o = rd_q;
  assign less_o    = lt_q;
  assign equal_o   = eq_q;
  assign greater_o = gt_q;
  assign status_o  = st_q;
endmodule

/* rtl/rau_ctrl.sv */
// sequencing state machine
`timescale 1ns / 1ps
module rau_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rau_pkg::cmd_t cmd_o,
  input  rau_pkg::sts_t sts_i
);
  import rau_pkg::*;
  state_e state_q, state_d;
  logic   pend_q, pend_d;

  always_comb begin
    state_d = state_q;
    pend_d  = pend_q;
    case (state_q)
      StIdle:  if (in_valid_i) state_d = StLoad;
      StLoad:  state_d = sts_i.early_done ? StOut : StMul1;
      StMul1:  state_d = StMul2;
      StMul2:  state_d = StMul3;
      StMul3:  state_d = StSum;
      StSum:   state_d = StGcdChk;
      StGcdChk: begin
        if (sts_i.early_done) state_d = StOut;
        else if (sts_i.gcd_done) begin state_d = StDivN; pend_d = 1'b1; end
        else begin state_d = StGcdStep; pend_d = 1'b1; end
      end
      StGcdStep: if (sts_i.mod_done) state_d = StGcdChk;
      StDivN: if (!pend_q && sts_i.mod_done) begin state_d = StDivD; pend_d = 1'b1; end
              else pend_d = 1'b0;
      StDivD: if (!pend_q && sts_i.mod_done) state_d = StCheck; else pend_d = 1'b0;
      StCheck: state_d = StOut;
      StOut:   if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o  = (state_q == StIdle);
    out_valid_o = (state_q == StOut);
    case (state_q)
      StIdle:    cmd_o.load = in_valid_i;
      StMul1:    cmd_o.mul1 = 1'b1;
      StMul2:    cmd_o.mul2 = 1'b1;
      StMul3:    cmd_o.mul3 = 1'b1;
      StSum:     cmd_o.sum  = 1'b1;
      StGcdChk:  cmd_o.gcd_step = !sts_i.early_done && !sts_i.gcd_done;
      StDivN:    cmd_o.div_n_start = pend_q;
      StDivD:    cmd_o.div_d_start = pend_q;
      StCheck:   cmd_o.check = 1'b1;
      default:   cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end
endmodule

/* rtl/rational_arithmetic_unit_core.sv */
// top level of the rational arithmetic unit
//
// channel | signals                          | dir
// in      | in_valid_i / in_ready_o, fields  | sink
// out     | out_valid_o / out_ready_i, fields| source
//
// one word at a time; compare words end after the sum, error or unknown-code
// words right after load, and an idle state comes before the next word
// arithmetic words run the gcd remainder steps and the two reducing
// divisions, all through one shared bit-serial 64 bit divider
// reset clears the controller and divider control; operand registers carry no reset
// a result held on the output stalls the input until it is taken
`timescale 1ns / 1ps
module rational_arithmetic_unit_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  func_i,
  input  logic [31:0] a_num_i,
  input  logic [31:0] a_den_i,
  input  logic [31:0] b_num_i,
  input  logic [31:0] b_den_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] res_num_o,
  output logic [30:0] res_den_o,
  output logic        less_o,
  output logic        equal_o,
  output logic        greater_o,
  output logic [1:0]  status_o
);
  import rau_pkg::*;
  cmd_t cmd;
  sts_t sts;

  // sequencer
  rau_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .cmd_o(cmd), .sts_i(sts)
  );

  // arithmetic datapath
  rau_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .func_i,
    .a_num_i, .a_den_i, .b_num_i, .b_den_i,
    .res_num_o, .res_den_o, .less_o, .equal_o, .greater_o, .status_o
  );
endmodule

/* tb/sv/rational_arithmetic_unit_core_tb.sv */
// testbench for the rational arithmetic unit: directed and random words against an own predictor
`timescale 1ns / 1ps
module rational_arithmetic_unit_core_tb;
  import rau_pkg::*;

  typedef struct {
    logic        neg;
    logic [63:0] mag;
  } smag_t;

  typedef struct {
    logic [31:0] num;
    logic [30:0] den;
    logic        lt;
    logic        eq;
    logic        gt;
    logic [1:0]  status;
  } rat_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [3:0]  func_i = '0;
  logic [31:0] a_num_i = '0;
  logic [31:0] a_den_i = '0;
  logic [31:0] b_num_i = '0;
  logic [31:0] b_den_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] res_num_o;
  logic [30:0] res_den_o;
  logic        less_o;
  logic        equal_o;
  logic        greater_o;
  logic [1:0]  status_o;

  rat_result_t pending_results[$];
  int          mismatches = 0;
  bit          quiet = 1'b0;     // no idling on either side while set
  int          out_hold = 0;     // long receiver hold-off, cycles left

  rational_arithmetic_unit_core u_top (.*);

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor: exact sign-magnitude arithmetic, then gcd reduction
  // ---------------------------------------------------------------------------
  function automatic smag_t to_sm(logic [31:0] v);
    smag_t  r;
    longint s;
    s = longint'($signed(v));
    r.neg = v[31];
    r.mag = r.neg ? 64'(-s) : 64'(s);
    return r;
  endfunction

  function automatic smag_t sm_mul(smag_t x, smag_t y);
    smag_t r;
    r.neg = x.neg != y.neg;
    r.mag = x.mag * y.mag;
    return r;
  endfunction

  function automatic smag_t sm_add(smag_t x, smag_t y);
    smag_t r;
    if (x.neg == y.neg) begin
      r.neg = x.neg;
      r.mag = x.mag + y.mag;
    end else if (x.mag >= y.mag) begin
      r.neg = x.neg;
      r.mag = x.mag - y.mag;
    end else begin
      r.neg = y.neg;
      r.mag = y.mag - x.mag;
    end
    return r;
  endfunction

  function automatic smag_t sm_neg(smag_t x);
    x.neg = !x.neg;
    return x;
  endfunction

  // lowest terms, positive denominator, overflow instead of wrapping
  function automatic rat_result_t reduce_frac(smag_t n, smag_t d);
    rat_result_t r;
    logic [63:0] x, y, t, nm, dm;
    logic [63:0] lim;
    logic        neg;
    r = '{default: '0};
    lim = 64'h7FFF_FFFF;
    x = n.mag;
    y = d.mag;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    nm = n.mag / x;
    dm = d.mag / x;
    neg = (nm != 0) && (n.neg != d.neg);
    if (dm > lim || nm > (neg ? lim + 1 : lim)) begin
      r.status = StatusOvf;
    end else begin
      r.num = neg ? -nm[31:0] : nm[31:0];
      r.den = dm[30:0];
    end
    return r;
  endfunction

  function automatic rat_result_t predict_result(logic [3:0] f, logic [31:0] an_w,
      logic [31:0] ad_w, logic [31:0] bn_w, logic [31:0] bd_w);
    rat_result_t r;
    smag_t       an, ad, bn, bd, dn, dd;
    logic        binary;
    r = '{default: '0};
    an = to_sm(an_w);
    ad = to_sm(ad_w);
    bn = to_sm(bn_w);
    bd = to_sm(bd_w);
    binary = (f <= FuncDiv) || (f == FuncCmp);
    if (f > FuncCmp) return r;
    if (ad.mag == 0 || (binary && bd.mag == 0)) begin
      r.status = StatusZero;
      return r;
    end
    case (f)
      FuncAdd: r = reduce_frac(sm_add(sm_mul(an, bd), sm_mul(bn, ad)), sm_mul(ad, bd));
      FuncSub: r = reduce_frac(sm_add(sm_mul(an, bd), sm_neg(sm_mul(bn, ad))),
                               sm_mul(ad, bd));
      FuncMul: r = reduce_frac(sm_mul(an, bn), sm_mul(ad, bd));
      FuncDiv: begin
        if (bn.mag == 0) r.status = StatusZero;
        else r = reduce_frac(sm_mul(an, bd), sm_mul(ad, bn));
      end
      FuncNeg: r = reduce_frac(sm_neg(an), ad);
      FuncInc: r = reduce_frac(sm_add(an, ad), ad);
      FuncDec: r = reduce_frac(sm_add(an, sm_neg(ad)), ad);
      FuncRed: r = reduce_frac(an, ad);
      default: begin
        dn = sm_add(sm_mul(an, bd), sm_neg(sm_mul(bn, ad)));
        dd = sm_mul(ad, bd);
        if (dn.mag == 0) r.eq = 1'b1;
        else if (dn.neg != dd.neg) r.lt = 1'b1;
        else r.gt = 1'b1;
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // sender: one word per call, random gap afterwards
  // ---------------------------------------------------------------------------
  task automatic send_word(logic [3:0] f, logic [31:0] an, logic [31:0] ad,
                           logic [31:0] bn, logic [31:0] bd);
    int gap;
    in_valid_i <= 1'b1;
    func_i     <= f;
    a_num_i    <= an;
    a_den_i    <= ad;
    b_num_i    <= bn;
    b_den_i    <= bd;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(predict_result(f, an, ad, bn, bd));
    gap = quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    mismatches++;
  endtask

  // long hold-off counted down one per cycle
  initial begin : hold_timer
    forever begin
      @(posedge clk_i);
      if (out_hold > 0) out_hold--;
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stall per word, long hold when asked, check each word
  // ---------------------------------------------------------------------------
  initial begin : result_checker
    int          stall;
    rat_result_t want;
    @(posedge rst_ni);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      while (out_hold > 0) begin
        out_ready_i <= 1'b0;
        @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", res_num_o, 0);
      end else begin
        want = pending_results.pop_front();
        if (res_num_o !== want.num)    report_mismatch("res_num", res_num_o, want.num);
        if (res_den_o !== want.den)    report_mismatch("res_den", res_den_o, want.den);
        if (less_o !== want.lt)        report_mismatch("less", less_o, want.lt);
        if (equal_o !== want.eq)       report_mismatch("equal", equal_o, want.eq);
        if (greater_o !== want.gt)     report_mismatch("greater", greater_o, want.gt);
        if (status_o !== want.status)  report_mismatch("status", status_o, want.status);
      end
    end
  end

  // operand value: mostly small so the gcd stays short, some full range and extremes
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1:    return $urandom();
      2:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      3:       return 32'($signed($urandom_range(0, 2_000_000)) - 1_000_000);
      default: return 32'($signed($urandom_range(0, 200)) - 100);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_each_func();
    send_word(FuncAdd, 32'd1, 32'd2, 32'd1, 32'd3);
    send_word(FuncSub, 32'd1, 32'd2, 32'd1, -32'd2);
    send_word(FuncMul, -32'd4, 32'd6, 32'd3, -32'd8);
    send_word(FuncDiv, 32'd3, 32'd4, -32'd9, 32'd8);
    send_word(FuncNeg, 32'd6, -32'd4, 32'd0, 32'd0);   // b ignored, zero b_den fine
    send_word(FuncInc, -32'd7, 32'd3, 32'd5, 32'd0);
    send_word(FuncDec, 32'd7, 32'd3, 32'd1, 32'd1);
    send_word(FuncRed, 32'd0, -32'd5, 32'd1, 32'd1);   // zero comes out as 0/1
    send_word(FuncCmp, 32'd1, 32'd3, 32'd2, 32'd6);    // equal
    send_word(FuncCmp, -32'd1, 32'd3, 32'd1, -32'd3);  // equal across signs
    send_word(FuncCmp, 32'd1, -32'd3, 32'd1, 32'd3);   // less
    send_word(FuncCmp, 32'd1, 32'd2, 32'd1, 32'd3);    // greater
    send_word(4'd9, 32'd1, 32'd1, 32'd1, 32'd1);       // unknown code
    send_word(4'd15, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0);
  endtask

  task automatic test_edges();
    // zero denominators and zero divisor
    send_word(FuncRed, 32'd5, 32'd0, 32'd1, 32'd1);
    send_word(FuncAdd, 32'd5, 32'd1, 32'd1, 32'd0);
    send_word(FuncDiv, 32'd5, 32'd1, 32'd0, 32'd7);
    // overflow of numerator and denominator, and extreme operands that still fit
    send_word(FuncNeg, 32'h8000_0000, 32'd1, 32'd0, 32'd0);
    send_word(FuncRed, 32'd5, 32'h8000_0000, 32'd0, 32'd0);
    send_word(FuncInc, 32'h7FFF_FFFF, 32'd1, 32'd0, 32'd0);
    send_word(FuncMul, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_word(FuncMul, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'd1);
    send_word(FuncRed, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0);
    send_word(FuncCmp, 32'h8000_0000, 32'd1, 32'h7FFF_FFFF, 32'd1);
  endtask

  task automatic test_random(int count);
    logic [3:0] f;
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) quiet = ($urandom_range(0, 3) == 0);
      f = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(9, 15))
                                       : 4'($urandom_range(0, 8));
      send_word(f, pick_value(), pick_value(), pick_value(), pick_value());
    end
    quiet = 1'b0;
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    out_hold = 1500;
    for (int i = 0; i < 6; i++)
      send_word(FuncCmp, pick_value(), 32'd3, pick_value(), 32'd5);
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_each_func();
    test_edges();
    test_backpressure();
    test_random(730);
    in_valid_i <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (7000) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("rational_arithmetic_unit_core_tb OK");
    end else begin
      $display("rational_arithmetic_unit_core_tb NOT OK");
    end
    $finish;
  end

  // hard stop well past the slowest correct run
  initial begin : watchdog
    #200_000_000;
    $display("rational_arithmetic_unit_core_tb NOT OK");
    $finish;
  end
endmodule
